// ===== sv/lph_pkg.sv =====
// shared types, codes and reset values for the line polarity hunter
package lph_pkg;

    localparam int unsigned CNT_W = 32;
    localparam int unsigned THR_W = 16;
    localparam int unsigned CFG_IDX_W = 2;
    localparam int unsigned CFG_DATA_W = 32;

    // command codes
    localparam logic [1:0] CMD_OBSERVE   = 2'd0;
    localparam logic [1:0] CMD_CONFIGURE = 2'd1;
    localparam logic [1:0] CMD_TAKE      = 2'd2;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_LOCK_FRAMES   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_HUNT_ERRORS   = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_UNLOCK_ERRORS = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_DWELL_MS      = 2'd3;

    // configuration reset values
    localparam logic [THR_W-1:0] RST_LOCK_FRAMES   = 16'd4;
    localparam logic [THR_W-1:0] RST_HUNT_ERRORS   = 16'd8;
    localparam logic [THR_W-1:0] RST_UNLOCK_ERRORS = 16'd32;
    localparam logic [CNT_W-1:0] RST_DWELL_MS      = 32'd500;

    typedef enum logic [1:0] {
        MODE_NORMAL   = 2'd0,
        MODE_INVERTED = 2'd1,
        MODE_AUTO     = 2'd2
    } t_mode;

    typedef struct packed {
        logic [1:0]       command;
        logic [1:0]       mode_sel;
        logic             start_inverted;
        logic [CNT_W-1:0] rx_byte_count;
        logic [CNT_W-1:0] frame_count;
        logic [CNT_W-1:0] error_count;
        logic [CNT_W-1:0] time_ms;
    } t_in_item;

    typedef struct packed {
        logic             did_flip;
        logic             polarity_inverted;
        logic             is_locked;
        logic             lock_event;
        logic [CNT_W-1:0] flip_total;
    } t_out_item;

    typedef struct packed {
        logic [THR_W-1:0] lock_frames;
        logic [THR_W-1:0] hunt_errors;
        logic [THR_W-1:0] unlock_errors;
        logic [CNT_W-1:0] dwell_ms;
    } t_cfg;

    typedef struct packed {
        t_mode            mode;
        logic             inverted;
        logic             locked;
        logic             lock_pending;
        logic [CNT_W-1:0] base_rx_bytes;
        logic [CNT_W-1:0] base_frames;
        logic [CNT_W-1:0] base_errors;
        logic [CNT_W-1:0] last_flip_time;
        logic             has_flipped;
        logic [CNT_W-1:0] flip_counter;
    } t_state;

endpackage

// ===== sv/line_polarity_hunter.sv =====
// top level of the line polarity hunter: input register, decision logic, result register
//
//   channel   direction  handshake                    payload
//   in        to block   i_in_valid / o_in_stall      i_in_data  (lph_pkg::t_in_item)
//   out       from block o_out_valid / i_out_stall    o_out_data (lph_pkg::t_out_item)
//   cfg       to block   i_cfg_we                     i_cfg_index, i_cfg_data
//
// one item per cycle unless the output stalls; items pass input, then result register
// the hunter state updates in the same edge that moves an item from the input register
// to the result register, so the next item always sees the state left by the previous one
// synchronous active-low reset clears the hunter state, both valid flags and the
// configuration registers to their defaults; no item is held after reset
// a stall on the output holds the result register and then the input register,
// and only then is the input stalled
module line_polarity_hunter (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    // item input
    input  logic                              i_in_valid,
    output logic                              o_in_stall,
    input  lph_pkg::t_in_item                 i_in_data,
    // result output
    output logic                              o_out_valid,
    input  logic                              i_out_stall,
    output lph_pkg::t_out_item                o_out_data,
    // configuration writes
    input  logic                              i_cfg_we,
    input  logic [lph_pkg::CFG_IDX_W-1:0]     i_cfg_index,
    input  logic [lph_pkg::CFG_DATA_W-1:0]    i_cfg_data
);

    lph_pkg::t_cfg       cfg;

    // input register
    logic                r_in_valid;
    logic                n_in_valid;
    lph_pkg::t_in_item   r_in;

    // result register
    logic                r_out_valid;
    logic                n_out_valid;
    lph_pkg::t_out_item  r_out;

    // hunter state
    lph_pkg::t_state     r_state;
    lph_pkg::t_state     n_state;
    lph_pkg::t_out_item  result;

    logic                in_xfer;
    logic                advance;

    lph_cfg_regs u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_cfg       (cfg)
    );

    lph_decide u_decide (
        .i_item   (r_in),
        .i_state  (r_state),
        .i_cfg    (cfg),
        .o_state  (n_state),
        .o_result (result)
    );

    // the held item moves on whenever the result register is free or being emptied
    assign advance    = r_in_valid && (!r_out_valid || !i_out_stall);
    assign o_in_stall = r_in_valid && !advance;
    assign in_xfer    = i_in_valid && !o_in_stall;

    assign n_in_valid  = in_xfer || (r_in_valid && !advance);
    assign n_out_valid = advance || (r_out_valid && i_out_stall);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
            r_state     <= '0;
        end else begin
            r_in_valid  <= n_in_valid;
            r_out_valid <= n_out_valid;
            if (advance) begin
                r_state <= n_state;
            end
        end
    end

    // payload registers, no reset needed
    always_ff @(posedge i_clk) begin
        if (in_xfer) begin
            r_in <= i_in_data;
        end
        if (advance) begin
            r_out <= result;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

endmodule

// ===== sv/lph_cfg_regs.sv =====
// configuration register bank of the line polarity hunter
module lph_cfg_regs (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_cfg_we,
    input  logic [lph_pkg::CFG_IDX_W-1:0]     i_cfg_index,
    input  logic [lph_pkg::CFG_DATA_W-1:0]    i_cfg_data,
    output lph_pkg::t_cfg                     o_cfg
);

    lph_pkg::t_cfg r_cfg;
    lph_pkg::t_cfg n_cfg;

    always_comb begin
        n_cfg = r_cfg;
        if (i_cfg_we) begin
            case (i_cfg_index)
                lph_pkg::CFG_LOCK_FRAMES:   n_cfg.lock_frames   = i_cfg_data[lph_pkg::THR_W-1:0];
                lph_pkg::CFG_HUNT_ERRORS:   n_cfg.hunt_errors   = i_cfg_data[lph_pkg::THR_W-1:0];
                lph_pkg::CFG_UNLOCK_ERRORS: n_cfg.unlock_errors = i_cfg_data[lph_pkg::THR_W-1:0];
                lph_pkg::CFG_DWELL_MS:      n_cfg.dwell_ms      = i_cfg_data[lph_pkg::CNT_W-1:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.lock_frames   <= lph_pkg::RST_LOCK_FRAMES;
            r_cfg.hunt_errors   <= lph_pkg::RST_HUNT_ERRORS;
            r_cfg.unlock_errors <= lph_pkg::RST_UNLOCK_ERRORS;
            r_cfg.dwell_ms      <= lph_pkg::RST_DWELL_MS;
        end else begin
            r_cfg <= n_cfg;
        end
    end

    assign o_cfg = r_cfg;

endmodule

// ===== sv/lph_decide.sv =====
// per-command decision logic: next hunter state and the result item
module lph_decide (
    input  lph_pkg::t_in_item   i_item,
    input  lph_pkg::t_state     i_state,
    input  lph_pkg::t_cfg       i_cfg,
    output lph_pkg::t_state     o_state,
    output lph_pkg::t_out_item  o_result
);

    logic                      went_back;
    logic [lph_pkg::CNT_W-1:0] new_frames;
    logic [lph_pkg::CNT_W-1:0] new_errors;
    logic [lph_pkg::CNT_W-1:0] frames_needed;
    logic [lph_pkg::CNT_W-1:0] errors_needed;
    logic [lph_pkg::CNT_W-1:0] since_flip;
    logic                      dwell_ok;
    logic                      flip;
    logic                      event_out;
    lph_pkg::t_state           n_state;

    // any counter below its baseline means the receiver was reset
    assign went_back = (i_item.rx_byte_count < i_state.base_rx_bytes)
                    || (i_item.frame_count < i_state.base_frames)
                    || (i_item.error_count < i_state.base_errors);

    assign new_frames = i_item.frame_count - i_state.base_frames;
    assign new_errors = i_item.error_count - i_state.base_errors;

    // once locked a single fresh frame keeps the lock
    assign frames_needed = i_state.locked ? lph_pkg::CNT_W'(1)
                         : {{(lph_pkg::CNT_W-lph_pkg::THR_W){1'b0}}, i_cfg.lock_frames};
    assign errors_needed = {{(lph_pkg::CNT_W-lph_pkg::THR_W){1'b0}},
                            i_state.locked ? i_cfg.unlock_errors : i_cfg.hunt_errors};

    assign since_flip = i_item.time_ms - i_state.last_flip_time;
    assign dwell_ok   = !i_state.has_flipped || (since_flip >= i_cfg.dwell_ms);

    always_comb begin
        n_state   = i_state;
        flip      = 1'b0;
        event_out = 1'b0;
        case (i_item.command)
            lph_pkg::CMD_OBSERVE: begin
                if (i_state.mode == lph_pkg::MODE_AUTO) begin
                    if (went_back) begin
                        n_state.base_rx_bytes = i_item.rx_byte_count;
                        n_state.base_frames   = i_item.frame_count;
                        n_state.base_errors   = i_item.error_count;
                    end else if (new_frames >= frames_needed) begin
                        if (!i_state.locked) begin
                            n_state.locked       = 1'b1;
                            n_state.lock_pending = 1'b1;
                        end
                        n_state.base_rx_bytes = i_item.rx_byte_count;
                        n_state.base_frames   = i_item.frame_count;
                        n_state.base_errors   = i_item.error_count;
                    end else if ((new_errors >= errors_needed) && dwell_ok) begin
                        flip                   = 1'b1;
                        n_state.inverted       = !i_state.inverted;
                        n_state.locked         = 1'b0;
                        n_state.lock_pending   = 1'b0;
                        n_state.flip_counter   = i_state.flip_counter + lph_pkg::CNT_W'(1);
                        n_state.last_flip_time = i_item.time_ms;
                        n_state.has_flipped    = 1'b1;
                        n_state.base_rx_bytes  = i_item.rx_byte_count;
                        n_state.base_frames    = i_item.frame_count;
                        n_state.base_errors    = i_item.error_count;
                    end
                end
            end
            lph_pkg::CMD_CONFIGURE: begin
                // unknown selector falls back to normal
                if (i_item.mode_sel inside {lph_pkg::MODE_INVERTED, lph_pkg::MODE_AUTO}) begin
                    n_state.mode = lph_pkg::t_mode'(i_item.mode_sel);
                end else begin
                    n_state.mode = lph_pkg::MODE_NORMAL;
                end
                n_state.inverted       = i_item.start_inverted;
                n_state.locked         = 1'b0;
                n_state.lock_pending   = 1'b0;
                n_state.base_rx_bytes  = i_item.rx_byte_count;
                n_state.base_frames    = i_item.frame_count;
                n_state.base_errors    = i_item.error_count;
                n_state.last_flip_time = i_item.time_ms;
                n_state.has_flipped    = 1'b1;
            end
            lph_pkg::CMD_TAKE: begin
                event_out            = i_state.lock_pending;
                n_state.lock_pending = 1'b0;
            end
            default: ;
        endcase
    end

    assign o_state                    = n_state;
    assign o_result.did_flip          = flip;
    assign o_result.polarity_inverted = n_state.inverted;
    assign o_result.is_locked         = n_state.locked;
    assign o_result.lock_event        = event_out;
    assign o_result.flip_total        = n_state.flip_counter;

endmodule

// ===== sv/lph_checker.sv =====
// port-level checks for the line polarity hunter, bound to the top level
module lph_checker (
    input logic                i_clk,
    input logic                i_rst_n,
    input logic                o_out_valid,
    input logic                i_out_stall,
    input lph_pkg::t_out_item  o_out_data
);

    // a stalled result stays put
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid && $stable(o_out_data))
        else $error("stalled result changed");

    // nothing left over from before reset
    a_rst_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("result valid straight after reset");

    // a flip always drops the lock
    a_flip_unlocks: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_data.did_flip |-> !o_out_data.is_locked)
        else $error("flip reported while locked");

    // a pending lock event only exists while locked
    a_event_locked: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_data.lock_event |-> o_out_data.is_locked
            && !o_out_data.did_flip)
        else $error("lock event without lock");

endmodule

bind line_polarity_hunter lph_checker u_lph_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .o_out_valid (o_out_valid),
    .i_out_stall (i_out_stall),
    .o_out_data  (o_out_data)
);
